[rtl/w3f_pkg.sv]
// package for the 3x3 window image filter: constants and shared types
package w3f_pkg;
  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 4096;

  localparam logic [1:0] ModeBox     = 2'd0;
  localparam logic [1:0] ModeGauss   = 2'd1;
  localparam logic [1:0] ModeSharpen = 2'd2;
  localparam logic [1:0] ModeSobel   = 2'd3;

  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;
  localparam logic [1:0] RegThresh = 2'd3;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  // one pixel of the window, packed R | G<<8 | B<<16 | A<<24
  typedef logic [31:0] pixel_t;

  // what travels with a pixel into the arithmetic pipeline
  typedef struct packed {
    logic       valid;
    logic       inner;
    logic       frame_end;
    logic [1:0] mode;
  } ctl_t;
endpackage

[rtl/w3f_arith.sv]
// filter arithmetic: window in, filtered pixel out, four register stages
module w3f_arith
  import w3f_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  ctl_t        ctl_i,
  input  pixel_t      win_i [9],
  input  logic [10:0] thresh_i,
  output ctl_t        ctl_o,
  output pixel_t      pix_o
);
  // stage 1: weighted sums
  ctl_t               ctl1_q;
  logic signed [13:0] sum1_q [3];
  logic signed [11:0] hs_q, vs_q;
  pixel_t             ctr1_q;
  // stage 2: squares added, divides done
  ctl_t               ctl2_q;
  logic [7:0]         res2_q [3];
  logic [20:0]        mag2_q;
  pixel_t             ctr2_q;
  // stage 3: upper six steps of the square root
  ctl_t               ctl3_q;
  logic [7:0]         res3_q [3];
  logic [10:0]        root3_q;
  logic [21:0]        rem3_q;
  logic [9:0]         low3_q;
  pixel_t             ctr3_q;
  // stage 4: lower five steps of the root, then select
  ctl_t               ctl4_q;
  pixel_t             pix4_q;

  logic signed [13:0] sum_d [3];
  logic signed [11:0] hs_d, vs_d;

  function automatic logic signed [13:0] ch(pixel_t p, int k);
    return $signed({6'd0, p[8*k +: 8]});
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (ctl_i.mode)
        ModeBox: sum_d[k] = ch(win_i[0],k)+ch(win_i[1],k)+ch(win_i[2],k)+ch(win_i[3],k)
                   +ch(win_i[4],k)+ch(win_i[5],k)+ch(win_i[6],k)+ch(win_i[7],k)
                   +ch(win_i[8],k);
        ModeGauss: sum_d[k] = ch(win_i[0],k)+(ch(win_i[1],k)<<<1)+ch(win_i[2],k)
                   +(ch(win_i[3],k)<<<1)+(ch(win_i[4],k)<<<2)+(ch(win_i[5],k)<<<1)
                   +ch(win_i[6],k)+(ch(win_i[7],k)<<<1)+ch(win_i[8],k);
        default: sum_d[k] = ch(win_i[4],k)*14'sd5 - ch(win_i[1],k) - ch(win_i[3],k)
                   - ch(win_i[5],k) - ch(win_i[7],k);
      endcase
    end
    hs_d = 12'(ch(win_i[0],0) - ch(win_i[2],0) + (ch(win_i[3],0)<<<1)
         - (ch(win_i[5],0)<<<1) + ch(win_i[6],0) - ch(win_i[8],0));
    vs_d = 12'(ch(win_i[0],0) + (ch(win_i[1],0)<<<1) + ch(win_i[2],0)
         - ch(win_i[6],0) - (ch(win_i[7],0)<<<1) - ch(win_i[8],0));
  end

  logic [7:0]  res_d [3];
  logic [20:0] mag_d;
  logic [23:0] div9;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // sums are non-negative, below 2296 for box and below 4081 for gauss
      div9 = 24'(sum1_q[k][11:0]) * 24'd3641;
      case (ctl1_q.mode)
        ModeBox:   res_d[k] = 8'(div9 >> 15);
        ModeGauss: res_d[k] = sum1_q[k][11:4];
        default:   res_d[k] = sum1_q[k] < 0 ? 8'd0 : (sum1_q[k] > 255 ? 8'd255
                               : sum1_q[k][7:0]);
      endcase
    end
    mag_d = 21'(hs_q * hs_q) + 21'(vs_q * vs_q);
  end

  // floor square root of a 21-bit value, upper six bit steps
  logic [21:0] mag_x;
  logic [10:0] root_a;
  logic [21:0] rem_a, trial_a;
  always_comb begin
    mag_x   = {1'b0, mag2_q};
    root_a  = '0;
    rem_a   = '0;
    trial_a = '0;
    for (int i = 10; i >= 5; i--) begin
      rem_a   = {rem_a[19:0], mag_x[2*i+1 -: 2]};
      trial_a = {9'd0, root_a, 2'b01};
      if (rem_a >= trial_a) begin
        rem_a  = rem_a - trial_a;
        root_a = {root_a[9:0], 1'b1};
      end else begin
        root_a = {root_a[9:0], 1'b0};
      end
    end
  end

  // lower five bit steps
  logic [10:0] root;
  logic [21:0] rem, trial;
  always_comb begin
    root  = root3_q;
    rem   = rem3_q;
    trial = '0;
    for (int i = 4; i >= 0; i--) begin
      rem   = {rem[19:0], low3_q[2*i+1 -: 2]};
      trial = {9'd0, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[9:0], 1'b1};
      end else begin
        root = {root[9:0], 1'b0};
      end
    end
  end

  logic [7:0] edge_v;
  always_comb begin
    edge_v = (root < thresh_i) ? 8'd0 : (root > 11'd255 ? 8'd255 : root[7:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum1_q  <= sum_d;
      hs_q    <= hs_d;
      vs_q    <= vs_d;
      ctr1_q  <= win_i[4];
      res2_q  <= res_d;
      mag2_q  <= mag_d;
      ctr2_q  <= ctr1_q;
      res3_q  <= res2_q;
      root3_q <= root_a;
      rem3_q  <= rem_a;
      low3_q  <= mag2_q[9:0];
      ctr3_q  <= ctr2_q;
      if (!ctl3_q.inner) pix4_q <= ctr3_q;
      else if (ctl3_q.mode == ModeSobel) pix4_q <= {ctr3_q[31:24], edge_v, edge_v, edge_v};
      else pix4_q <= {ctr3_q[31:24], res3_q[2], res3_q[1], res3_q[0]};
    end
  end

  assign ctl_o = ctl4_q;
  assign pix_o = pix4_q;
endmodule

[rtl/window_3x3_image_filter.sv]
// top level of the 3x3 window image filter
// Streams RGBA pixels in raster order, one transaction per clock when the output
// side keeps up; each result is the pixel that entered line_width+1 transactions
// earlier, filtered by the mode register (box, gaussian, sharpen, sobel on red).
// Two line memories with registered read hold the rows above. A pixel accepted at
// an edge reads its column from both memories; from stage 0 it then builds the
// window and writes back when the pipeline advances. The following pixel normally
// reads the next column; on one-pixel lines it reads the column still being
// written and takes the pending data instead of the memory output. Results run
// through a five-stage pipeline (window, sums, squares and divides, upper root,
// lower root and select) that advances only when its last stage is empty or
// taken, sustained rate one pixel per cycle while the output is not stalled.
// Borders and alpha pass unchanged. Writing line_width or frame_height restarts
// the stream and drops pixels not yet in the arithmetic stages.
module window_3x3_image_filter
  import w3f_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_red_i,
  input  logic [7:0]          in_green_i,
  input  logic [7:0]          in_blue_i,
  input  logic [7:0]          in_alpha_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_red_o,
  output logic [7:0]          out_green_o,
  output logic [7:0]          out_blue_o,
  output logic [7:0]          out_alpha_o,
  output logic                frame_end_o
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic [1:0]  mode_q;
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [10:0] thresh_q;

  // effective geometry, clamped
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  always_comb begin
    if (width_q == 11'd0) w_eff = CW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_q);
    if (height_q == 13'd0) h_eff = RW'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(height_q);
  end

  // pipeline control
  ctl_t   ar_ctl;
  pixel_t ar_pix;
  logic   adv;
  assign adv        = !ar_ctl.valid || !out_stall_i;
  assign in_stall_o = !adv;
  logic acc;
  assign acc = in_valid_i && adv;

  // input position and output position counters
  logic [CW-1:0] col_q, ocol_q;
  logic [RW-1:0] row_q, orow_q;
  logic [CW:0]   fill_q;
  logic geo_wr;
  assign geo_wr = cfg_we_i && (cfg_idx_i == CfgIdxW'(RegWidth) ||
                               cfg_idx_i == CfgIdxW'(RegHeight));

  // line memories
  pixel_t upper_mem [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];
  pixel_t up_rd_q, mid_rd_q;
  logic   s0_q;
  logic [AW-1:0] s0_addr_q;
  pixel_t s0_px_q;
  logic   s0_emit_q, s0_inner_q, s0_end_q;

  logic [AW-1:0] rd_addr;
  assign rd_addr = AW'(col_q);

  // same column read while its write-back is pending
  logic fwd;
  assign fwd = s0_q && (s0_addr_q == rd_addr);

  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (fwd) begin
        up_rd_q  <= mid_rd_q;
        mid_rd_q <= s0_px_q;
      end else begin
        up_rd_q  <= upper_mem[rd_addr];
        mid_rd_q <= middle_mem[rd_addr];
      end
    end
    if (s0_q && adv) begin
      upper_mem[s0_addr_q]  <= mid_rd_q;
      middle_mem[s0_addr_q] <= s0_px_q;
    end
  end

  logic last_col, last_row, olast_col, olast_row;
  assign last_col  = (col_q + CW'(1)) >= w_eff;
  assign last_row  = (row_q + RW'(1)) >= h_eff;
  assign olast_col = (ocol_q + CW'(1)) >= w_eff;
  assign olast_row = (orow_q + RW'(1)) >= h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeBox;
      width_q  <= 11'd640;
      height_q <= 13'd480;
      thresh_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
      fill_q   <= '0;
      s0_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgIdxW'(RegMode):   mode_q   <= cfg_data_i[1:0];
          CfgIdxW'(RegWidth):  width_q  <= cfg_data_i[10:0];
          CfgIdxW'(RegHeight): height_q <= cfg_data_i;
          CfgIdxW'(RegThresh): thresh_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (geo_wr) begin
        col_q  <= '0;
        row_q  <= '0;
        ocol_q <= '0;
        orow_q <= '0;
        fill_q <= '0;
      end else if (acc) begin
        col_q <= last_col ? '0 : col_q + CW'(1);
        if (last_col) row_q <= last_row ? '0 : row_q + RW'(1);
        if (fill_q < {1'b0, w_eff} + (CW+1)'(1)) fill_q <= fill_q + (CW+1)'(1);
        else begin
          ocol_q <= olast_col ? '0 : ocol_q + CW'(1);
          if (olast_col) orow_q <= olast_row ? '0 : orow_q + RW'(1);
        end
      end
      if (adv) s0_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s0_addr_q  <= rd_addr;
      s0_px_q    <= {in_alpha_i, in_blue_i, in_green_i, in_red_i};
      s0_emit_q  <= !(fill_q < {1'b0, w_eff} + (CW+1)'(1)) && !geo_wr;
      s0_inner_q <= !(ocol_q < CW'(1) || olast_col || orow_q < RW'(1) || olast_row);
      s0_end_q   <= olast_col && olast_row;
    end
  end

  // window shift register, advanced when a pixel leaves stage 0
  pixel_t win_q [9];
  pixel_t win_d [9];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[3*i]   = win_q[3*i+1];
      win_d[3*i+1] = win_q[3*i+2];
    end
    win_d[2] = up_rd_q;
    win_d[5] = mid_rd_q;
    win_d[8] = s0_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (s0_q && adv) begin
      win_q <= win_d;
    end
  end

  // stage from window to arithmetic: window registered above, control here
  ctl_t w_ctl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_ctl_q <= '0;
    end else if (geo_wr) begin
      w_ctl_q <= '0;
    end else if (adv) begin
      w_ctl_q.valid     <= s0_q && s0_emit_q;
      w_ctl_q.inner     <= s0_inner_q;
      w_ctl_q.frame_end <= s0_end_q;
      w_ctl_q.mode      <= mode_q;
    end
  end

  w3f_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .ctl_i    (w_ctl_q),
    .win_i    (win_q),
    .thresh_i (thresh_q),
    .ctl_o    (ar_ctl),
    .pix_o    (ar_pix)
  );

  assign out_valid_o = ar_ctl.valid;
  assign out_red_o   = ar_pix[7:0];
  assign out_green_o = ar_pix[15:8];
  assign out_blue_o  = ar_pix[23:16];
  assign out_alpha_o = ar_pix[31:24];
  assign frame_end_o = ar_ctl.frame_end;
endmodule

[rtl/w3f_checker.sv]
// port-level checks for the 3x3 window image filter, bound to the top level
module w3f_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_alpha_o
);
  // a waiting result stays valid and holds its alpha
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_alpha_o))
    else $error("stalled result changed");
  // input is only stalled while a result is stuck
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");
  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");
endmodule

bind window_3x3_image_filter w3f_checker u_w3f_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_alpha_o (out_alpha_o)
);
